// File: design/cpms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_pkg: shared types and constants
// Item kinds, command and status structs and the controller state type.
// ----------------------------------------------------------------------------
package cpms_pkg;

	localparam int MaxPlanes = 16;
	localparam int SlotW = $clog2(MaxPlanes);
	localparam int CountW = $clog2(MaxPlanes + 1);

	// Accumulator width: three 48-bit products, an offset and a height term.
	localparam int AccW = 52;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_CLIP = 2'd1;
	localparam logic [1:0] KIND_GRAV = 2'd2;
	localparam logic [1:0] KIND_INTEG = 2'd3;

	localparam logic [3:0] MASK_CLIP = 4'h7;
	localparam logic [3:0] MASK_GRAV = 4'h1;
	localparam logic [3:0] MASK_INTEG = 4'h9;

	localparam logic [0:0] REG_GRAVITY = 1'd0;
	localparam logic [0:0] REG_TIMESTEP = 1'd1;

	localparam logic [30:0] RESET_GRAVITY = 31'd10703;
	localparam logic [30:0] RESET_TIMESTEP = 31'd1092;

	// Multiplier operand selection.
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_POS_N,
		MUL_HGT_N,
		MUL_VEL_N,
		MUL_N_PEN,
		MUL_N_VEL,
		MUL_VEL_DT
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD,
		ST_TOP,
		ST_BOT,
		ST_VEL,
		ST_EVAL,
		ST_PUSH,
		ST_VCANCEL,
		ST_INTEG,
		ST_GRAV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        load;
		logic        write_plane;
		logic        init_acc;
		mul_op_t     op;
		logic [1:0]  lane;
		logic        eval;
		logic        grav;
		logic        set_skip;
		logic        issue;
		logic [SlotW-1:0] plane;
	} cmd_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        comp;
		logic [CountW-1:0] count;
		logic              slot_ok;
		logic              pen_neg;
		logic              vel_neg;
		logic              mul_busy;
	} status_t;

endpackage
`default_nettype wire

// File: design/cpms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_ram: generic single-port RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cpms_ram #(
	parameter int Width = 32,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic [Width-1:0]              rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Read before write, registered read of the addressed entry.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

// File: design/cpms_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_datapath: operand registers, plane store and one shared multiplier
// All products run through a single 32x32 multiplier with a registered result.
// ----------------------------------------------------------------------------
module cpms_datapath import cpms_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output status_t          status,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  plane_slot,
	input  wire logic [31:0] vec_a_x,
	input  wire logic [31:0] vec_a_y,
	input  wire logic [31:0] vec_a_z,
	input  wire logic [31:0] vec_b_x,
	input  wire logic [31:0] vec_b_y,
	input  wire logic [31:0] vec_b_z,
	input  wire logic [31:0] scalar_a,
	input  wire logic [30:0] scalar_b,
	input  wire logic [4:0]  plane_count,
	input  wire logic [3:0]  components,
	input  wire logic [30:0] gravity,
	input  wire logic [30:0] tstep,
	output logic [31:0]      position_x,
	output logic [31:0]      position_y,
	output logic [31:0]      position_z,
	output logic [31:0]      velocity_x,
	output logic [31:0]      velocity_y,
	output logic [31:0]      velocity_z,
	output logic             skipped,
	output logic             saturated,
	output logic             strobe
);

	localparam logic signed [AccW-1:0] Max32 = 52'sh0007FFFFFFF;
	localparam logic signed [AccW-1:0] Min32 = -52'sh00080000000;

	logic [31:0] p_q [3];
	logic [31:0] v_q [3];
	logic [31:0] hgt_q;
	logic [30:0] rad_q;
	logic [1:0]  kind_q;
	logic [3:0]  comp_q;
	logic [CountW-1:0] count_q;
	logic        slot_ok_q;
	logic [SlotW-1:0] slot_q;
	logic        sat_q;
	logic        skip_q;

	logic [31:0] nx, ny, nz, noff;
	logic signed [AccW-1:0] top_q;
	logic signed [AccW-1:0] vel_q;
	logic signed [AccW-1:0] bot_q;
	logic [30:0] mag_q;
	logic [30:0] vmag_q;
	logic signed [47:0] prod_q;
	logic [1:0]  plane_lane;
	logic        prod_valid_s1;
	logic [2:0]  prod_op_s1;
	logic [1:0]  prod_lane_s1;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic signed [63:0] mul_full;
	logic signed [AccW-1:0] pen;
	logic signed [AccW-1:0] low;
	logic signed [AccW-1:0] upd;
	logic signed [AccW-1:0] vel_now;
	logic signed [AccW-1:0] gv;
	logic [31:0] lane_n;

	// Plane store: four fields, one RAM each.
	logic [SlotW-1:0] ram_addr;
	logic ram_we;
	assign ram_addr = cmd.write_plane ? slot_q : cmd.plane;
	assign ram_we = cmd.write_plane;

	cpms_ram #(.Width(32), .Depth(MaxPlanes)) u_nx (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(p_q[0]), .rdata(nx));
	cpms_ram #(.Width(32), .Depth(MaxPlanes)) u_ny (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(p_q[1]), .rdata(ny));
	cpms_ram #(.Width(32), .Depth(MaxPlanes)) u_nz (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(p_q[2]), .rdata(nz));
	cpms_ram #(.Width(32), .Depth(MaxPlanes)) u_off (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(hgt_q), .rdata(noff));

	assign plane_lane = cmd.lane;

	// Normal component for the selected lane.
	always_comb begin
		case (plane_lane)
			2'd0:    lane_n = nx;
			2'd1:    lane_n = ny;
			default: lane_n = nz;
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			MUL_POS_N: begin
				mul_a = p_q[plane_lane];
				mul_b = lane_n;
			end
			MUL_HGT_N: begin
				mul_a = hgt_q;
				mul_b = ny;
			end
			MUL_VEL_N: begin
				mul_a = v_q[plane_lane];
				mul_b = lane_n;
			end
			MUL_N_PEN: begin
				mul_a = lane_n;
				mul_b = {1'b0, mag_q};
			end
			MUL_N_VEL: begin
				mul_a = lane_n;
				mul_b = {1'b0, vmag_q};
			end
			MUL_VEL_DT: begin
				mul_a = v_q[plane_lane];
				mul_b = {1'b0, tstep};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = $signed(mul_a) * $signed(mul_b);

	// Multiplier output register, floor shift by 16.
	always_ff @(posedge clk) begin
		prod_q <= mul_full[63:16];
		prod_op_s1 <= cmd.op;
		prod_lane_s1 <= cmd.lane;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_valid_s1 <= 1'b0;
		end else begin
			prod_valid_s1 <= (cmd.op != MUL_NONE);
		end
	end

	// Position or velocity lane plus scaled product, clamped on write-back.
	always_comb begin
		if (prod_op_s1 == MUL_N_VEL) begin
			upd = AccW'($signed(v_q[prod_lane_s1])) + AccW'(prod_q);
		end else begin
			upd = AccW'($signed(p_q[prod_lane_s1])) + AccW'(prod_q);
		end
	end

	assign low = (top_q < bot_q) ? top_q : bot_q;
	assign pen = low - AccW'($signed({1'b0, rad_q}));

	// Velocity dot product including the last lane still in the multiplier.
	assign vel_now = (prod_valid_s1 && prod_op_s1 == MUL_VEL_N)
		? vel_q + AccW'(prod_q) : vel_q;

	// Gravity on vertical velocity, wide subtract then clamp.
	assign gv = AccW'($signed(v_q[1])) - AccW'($signed({1'b0, gravity}));

	// Operand registers and accumulators.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q[0] <= vec_a_x;
			p_q[1] <= vec_a_y;
			p_q[2] <= vec_a_z;
			v_q[0] <= vec_b_x;
			v_q[1] <= vec_b_y;
			v_q[2] <= vec_b_z;
			hgt_q <= scalar_a;
			rad_q <= scalar_b;
			kind_q <= kind;
			comp_q <= components;
			slot_q <= plane_slot[SlotW-1:0];
			slot_ok_q <= ({1'b0, plane_slot} < 5'(MaxPlanes));
			count_q <= (plane_count > 5'(MaxPlanes)) ? CountW'(MaxPlanes)
				: CountW'(plane_count);
		end
		if (cmd.init_acc) begin
			top_q <= -AccW'($signed(noff));
			vel_q <= '0;
		end else if (prod_valid_s1) begin
			case (prod_op_s1)
				MUL_POS_N: top_q <= top_q + AccW'(prod_q);
				MUL_HGT_N: bot_q <= top_q - AccW'(prod_q);
				MUL_VEL_N: vel_q <= vel_q + AccW'(prod_q);
				MUL_N_PEN, MUL_VEL_DT: begin
					if (upd > Max32) begin
						p_q[prod_lane_s1] <= 32'h7FFFFFFF;
					end else if (upd < Min32) begin
						p_q[prod_lane_s1] <= 32'h80000000;
					end else begin
						p_q[prod_lane_s1] <= upd[31:0];
					end
				end
				MUL_N_VEL: begin
					if (upd > Max32) begin
						v_q[prod_lane_s1] <= 32'h7FFFFFFF;
					end else if (upd < Min32) begin
						v_q[prod_lane_s1] <= 32'h80000000;
					end else begin
						v_q[prod_lane_s1] <= upd[31:0];
					end
				end
				default: begin
				end
			endcase
		end
		if (cmd.eval) begin
			mag_q <= (-pen > Max32) ? 31'h7FFFFFFF : 31'(-pen);
			vmag_q <= (-vel_now > Max32) ? 31'h7FFFFFFF : 31'(-vel_now);
		end
		// Gravity write of velocity y.
		if (cmd.grav) begin
			v_q[1] <= (gv < Min32) ? 32'h80000000 : gv[31:0];
		end
	end

	// Saturation and skip flags, output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
			skip_q <= 1'b0;
			strobe <= 1'b0;
		end else begin
			if (cmd.load) begin
				sat_q <= 1'b0;
				skip_q <= 1'b0;
			end
			if (cmd.set_skip) begin
				skip_q <= 1'b1;
			end
			if (cmd.eval && pen < 0) begin
				if (-pen > Max32 || (vel_now < 0 && -vel_now > Max32)) begin
					sat_q <= 1'b1;
				end
			end
			if (prod_valid_s1 && (prod_op_s1 == MUL_N_PEN || prod_op_s1 == MUL_N_VEL
					|| prod_op_s1 == MUL_VEL_DT) && (upd > Max32 || upd < Min32)) begin
				sat_q <= 1'b1;
			end
			if (cmd.grav && gv < Min32) begin
				sat_q <= 1'b1;
			end
			strobe <= cmd.issue;
		end
	end

	// Result registers.
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			position_x <= p_q[0];
			position_y <= p_q[1];
			position_z <= p_q[2];
			velocity_x <= v_q[0];
			velocity_y <= v_q[1];
			velocity_z <= v_q[2];
			skipped <= skip_q;
			saturated <= sat_q;
		end
	end

	assign status.kind = kind_q;
	assign status.comp = comp_q;
	assign status.count = count_q;
	assign status.slot_ok = slot_ok_q;
	assign status.pen_neg = pen < 0;
	assign status.vel_neg = vel_q < 0;
	assign status.mul_busy = prod_valid_s1;

endmodule
`default_nettype wire

// File: design/cpms_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cpms_ctrl: sequencer for the motion step
// Walks the planes and issues at most one multiply per cycle to the datapath.
// ----------------------------------------------------------------------------
module cpms_ctrl import cpms_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire status_t status,
	output logic         busy,
	output cmd_t         cmd
);

	state_t state_q, state_d;
	logic [SlotW-1:0] plane_q;
	logic [CountW-1:0] plane_n;
	logic [1:0] lane_q;
	logic last_lane;

	assign last_lane = (lane_q == 2'd2);
	assign plane_n = CountW'(plane_q) + CountW'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				case (status.kind)
					KIND_LOAD: state_d = ST_IDLE;
					KIND_CLIP: begin
						if ((status.comp & MASK_CLIP) != MASK_CLIP || status.count == '0)
							state_d = ST_DONE;
						else
							state_d = ST_RD;
					end
					KIND_GRAV: begin
						if ((status.comp & MASK_GRAV) != MASK_GRAV) state_d = ST_DONE;
						else state_d = ST_GRAV;
					end
					default: begin
						if ((status.comp & MASK_INTEG) != MASK_INTEG) state_d = ST_DONE;
						else state_d = ST_INTEG;
					end
				endcase
			end
			ST_RD: state_d = ST_TOP;
			ST_TOP: if (last_lane) state_d = ST_BOT;
			ST_BOT: state_d = ST_VEL;
			ST_VEL: if (last_lane) state_d = ST_EVAL;
			ST_EVAL: begin
				if (status.pen_neg) state_d = ST_PUSH;
				else if (plane_n == status.count) state_d = ST_DONE;
				else state_d = ST_RD;
			end
			ST_PUSH: begin
				if (last_lane) begin
					if (status.vel_neg) state_d = ST_VCANCEL;
					else if (plane_n == status.count) state_d = ST_DONE;
					else state_d = ST_RD;
				end
			end
			ST_VCANCEL: begin
				if (last_lane) begin
					if (plane_n == status.count) state_d = ST_DONE;
					else state_d = ST_RD;
				end
			end
			ST_INTEG: if (last_lane) state_d = ST_DONE;
			ST_GRAV: state_d = ST_DONE;
			// Hold until the last product has been written back.
			ST_DONE: if (!status.mul_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		cmd = '0;
		cmd.plane = plane_q;
		cmd.lane = lane_q;
		cmd.op = MUL_NONE;
		busy = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.load = start;
			ST_DISPATCH: begin
				cmd.write_plane = (status.kind == KIND_LOAD) && status.slot_ok;
				cmd.set_skip = (status.kind == KIND_CLIP
					&& (status.comp & MASK_CLIP) != MASK_CLIP)
					|| (status.kind == KIND_GRAV
					&& (status.comp & MASK_GRAV) != MASK_GRAV)
					|| (status.kind == KIND_INTEG
					&& (status.comp & MASK_INTEG) != MASK_INTEG);
			end
			ST_RD: begin
			end
			ST_TOP: begin
				cmd.init_acc = (lane_q == 2'd0);
				cmd.op = MUL_POS_N;
			end
			ST_BOT: cmd.op = MUL_HGT_N;
			ST_VEL: cmd.op = MUL_VEL_N;
			ST_PUSH: cmd.op = MUL_N_PEN;
			ST_VCANCEL: cmd.op = MUL_N_VEL;
			ST_INTEG: cmd.op = MUL_VEL_DT;
			ST_GRAV: cmd.grav = 1'b1;
			ST_DONE: cmd.issue = !status.mul_busy;
			default: begin
			end
		endcase
		cmd.eval = (state_q == ST_EVAL);
	end

	// Plane and lane counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= '0;
			lane_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DISPATCH) plane_q <= '0;
			else if (state_q != state_d && state_d == ST_RD) plane_q <= plane_q + SlotW'(1);
			if (state_q != state_d || last_lane) lane_q <= '0;
			else if (state_q == ST_TOP || state_q == ST_VEL || state_q == ST_PUSH
				|| state_q == ST_VCANCEL || state_q == ST_INTEG) lane_q <= lane_q + 2'd1;
		end
	end

`ifndef ASSERT_OFF
	a_lane_range: assert property (@(posedge clk) disable iff (!arst_n)
		lane_q != 2'd3) else $error("lane counter out of range");
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DISPATCH)) else $error("request not taken");
	a_issue_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> !cmd.issue) else $error("double result");
`endif

endmodule
`default_nettype wire

// File: design/capsule_plane_motion_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// capsule_plane_motion_step: per-entity motion step in Q16.16
// Plane loading, capsule clipping, gravity and integration on request.
// ----------------------------------------------------------------------------
// Usage: drive the item fields and raise start while busy is low; the request
// is taken at that edge and busy rises. Kind 0 stores a plane and gives no
// result. Other kinds give one result, marked by strobe for one cycle, in
// which busy is already low. Clip takes each plane, forms its distance and
// the normal velocity, pushes the capsule out when it penetrates and cancels
// that velocity when it points inward. One shared 32x32 multiplier with a
// registered product forms every product. The receiver cannot stall:
// results are not held back. Reset clears the sequencer and restores the
// register defaults; the plane store holds no defined contents until
// loaded. Registers are written over the APB port, gravity_times_step at 0
// and time_step at 4; the user must write them only while idle, which the
// block does not enforce.
// ----------------------------------------------------------------------------
module capsule_plane_motion_step import cpms_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             strobe,
	input  wire logic [1:0]  kind,
	input  wire logic [3:0]  plane_slot,
	input  wire logic [31:0] vec_a_x,
	input  wire logic [31:0] vec_a_y,
	input  wire logic [31:0] vec_a_z,
	input  wire logic [31:0] vec_b_x,
	input  wire logic [31:0] vec_b_y,
	input  wire logic [31:0] vec_b_z,
	input  wire logic [31:0] scalar_a,
	input  wire logic [30:0] scalar_b,
	input  wire logic [4:0]  plane_count,
	input  wire logic [3:0]  components,
	output logic [31:0]      position_x,
	output logic [31:0]      position_y,
	output logic [31:0]      position_z,
	output logic [31:0]      velocity_x,
	output logic [31:0]      velocity_y,
	output logic [31:0]      velocity_z,
	output logic             skipped,
	output logic             saturated,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	cmd_t cmd;
	status_t status;
	logic [30:0] gravity_q;
	logic [30:0] tstep_q;
	logic [0:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[2];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= RESET_GRAVITY;
			tstep_q <= RESET_TIMESTEP;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			case (reg_idx)
				REG_GRAVITY:  gravity_q <= pwdata[30:0];
				REG_TIMESTEP: tstep_q <= pwdata[30:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_GRAVITY:  prdata = {1'b0, gravity_q};
			REG_TIMESTEP: prdata = {1'b0, tstep_q};
			default:      prdata = '0;
		endcase
	end

	cpms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.busy(busy), .cmd(cmd));

	cpms_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.kind(kind), .plane_slot(plane_slot),
		.vec_a_x(vec_a_x), .vec_a_y(vec_a_y), .vec_a_z(vec_a_z),
		.vec_b_x(vec_b_x), .vec_b_y(vec_b_y), .vec_b_z(vec_b_z),
		.scalar_a(scalar_a), .scalar_b(scalar_b), .plane_count(plane_count),
		.components(components), .gravity(gravity_q), .tstep(tstep_q),
		.position_x(position_x), .position_y(position_y), .position_z(position_z),
		.velocity_x(velocity_x), .velocity_y(velocity_y), .velocity_z(velocity_z),
		.skipped(skipped), .saturated(saturated), .strobe(strobe));

endmodule
`default_nettype wire
